// ===== design/prrs_pkg.sv =====
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types, constants and event codes of the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

	localparam int LEVELS_DEF      = 256;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int SCAN_CHUNK      = 16;

	localparam logic [7:0] QUANTUM_RESET = 8'd10;
	localparam logic [8:0] PHASE_SPAN    = 9'd256;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic [2:0] EV_QUEUED   = 3'd0;
	localparam logic [2:0] EV_ARR_DROP = 3'd1;
	localparam logic [2:0] EV_DISPATCH = 3'd2;
	localparam logic [2:0] EV_RUNNING  = 3'd3;
	localparam logic [2:0] EV_DONE     = 3'd4;
	localparam logic [2:0] EV_REQUEUED = 3'd5;
	localparam logic [2:0] EV_REQ_DROP = 3'd6;
	localparam logic [2:0] EV_IDLE     = 3'd7;

	typedef struct packed {
		logic        opcode;
		logic [15:0] task_id;
		logic [7:0]  task_priority;
		logic [7:0]  task_burst;
	} in_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] out_task_id;
		logic [7:0]  out_priority;
		logic [7:0]  remaining;
	} out_t;

endpackage

// ===== design/prrs_ptr_ram.sv =====
// ----------------------------------------------------------------------------
// prrs_ptr_ram
// Per-level head, tail and count memory; entries never written read as zero.
// ----------------------------------------------------------------------------
module prrs_ptr_ram
	import prrs_pkg::*;
#(
	parameter int N = LEVELS_DEF,
	parameter int W = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [(N>1?$clog2(N):1)-1:0] addr,
	input  logic [W-1:0]                 wdata,
	output logic [W-1:0]                 rdata
);

	logic [W-1:0] mem [N];
	logic [N-1:0] vld_q;
	logic         rvld_q;
	logic [W-1:0] rdat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[addr];
			if (we) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rdat_q <= mem[addr];
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	assign rdata = rvld_q ? rdat_q : '0;

endmodule

// ===== design/prrs_task_ram.sv =====
// ----------------------------------------------------------------------------
// prrs_task_ram
// Task store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module prrs_task_ram
	import prrs_pkg::*;
#(
	parameter int DEPTH = LEVELS_DEF * LEVEL_DEPTH_DEF,
	parameter int W     = 24
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [W-1:0]                     wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [W-1:0]                     rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== design/priority_round_robin_scheduler_top.sv =====
// path: arrival or requeuing tick runs ARR_RD, ARR_WR, EMIT to the output register; other
// busy tick and out-of-range arrival go straight to EMIT; dispatching tick scans 16-level
// chunks of the non-empty bitmap to the hit, DSP_RD, DSP_RD2, DSP_FIN, EMIT (idle: all)
// throughput: one transaction at a time, set by the sequencer and the single-port pointer
// memory; one result may wait in the output register, a second one holds the emit step
// reset: asynchronous, clears queues (valid bits), cpu state, phase, quantum=10
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_top
// Multilevel priority queue scheduler with round-robin quantum preemption.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_top
	import prrs_pkg::*;
#(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int ENT_W  = 2 * PTR_W + CNT_W;
	localparam int TDEPTH = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
	localparam int NCHK   = (LEVELS + SCAN_CHUNK - 1) / SCAN_CHUNK;
	localparam int CH_W   = (NCHK > 1) ? $clog2(NCHK) : 1;
	localparam int SCW    = $clog2(SCAN_CHUNK);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ARR_RD  = 3'd1;
	localparam logic [2:0] ST_ARR_WR  = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_DSP_RD  = 3'd4;
	localparam logic [2:0] ST_DSP_RD2 = 3'd5;
	localparam logic [2:0] ST_DSP_FIN = 3'd6;
	localparam logic [2:0] ST_EMIT    = 3'd7;

	logic [2:0]       state_q;
	logic [7:0]       quantum_q;
	logic [7:0]       phase_q;
	logic             started_q;
	logic             busy_q;
	logic [15:0]      cpu_id_q;
	logic [7:0]       cpu_pr_q;
	logic [7:0]       cpu_rem_q;
	logic [LVL_W-1:0] lvl_q;
	logic [15:0]      itm_id_q;
	logic [7:0]       itm_pr_q;
	logic [7:0]       itm_burst_q;
	logic             req_q;
	logic [CH_W-1:0]  chk_q;
	logic [LEVELS-1:0] ne_q;
	out_t             res_q;
	out_t             out_q;
	logic             out_valid_q;

	// pointer memory
	logic             ptr_we;
	logic [ENT_W-1:0] ptr_wdata;
	logic [ENT_W-1:0] ptr_rdata;
	logic [PTR_W-1:0] p_head;
	logic [PTR_W-1:0] p_tail;
	logic [CNT_W-1:0] p_cnt;
	logic [PTR_W:0]   head_inc;
	logic [PTR_W:0]   tail_inc;
	logic [PTR_W-1:0] head_nx;
	logic [PTR_W-1:0] tail_nx;
	logic             lvl_full;

	// task memory
	logic              t_we;
	logic [ADDR_W-1:0] t_waddr;
	logic [ADDR_W-1:0] t_raddr;
	logic [23:0]       t_rdata;
	logic [ADDR_W-1:0] lvl_base;

	// scan unit
	logic [NCHK*SCAN_CHUNK-1:0] ne_pad;
	logic [SCAN_CHUNK-1:0]      slice;
	logic [SCW-1:0]             first;
	logic                       hit;
	logic [CH_W+SCW:0]          found;

	// tick arithmetic
	logic [8:0] q_span;
	logic [8:0] ph_nx;
	logic [7:0] phase_nx;
	logic       expired;
	logic [7:0] rem_nx;
	logic       can_emit;

	assign {p_head, p_tail, p_cnt} = ptr_rdata;

	assign head_inc = {1'b0, p_head} + 1'b1;
	assign tail_inc = {1'b0, p_tail} + 1'b1;
	assign head_nx  = (head_inc >= (PTR_W+1)'(LEVEL_DEPTH)) ? '0 : head_inc[PTR_W-1:0];
	assign tail_nx  = (tail_inc >= (PTR_W+1)'(LEVEL_DEPTH)) ? '0 : tail_inc[PTR_W-1:0];
	assign lvl_full = p_cnt >= CNT_W'(LEVEL_DEPTH);

	assign lvl_base = ADDR_W'(lvl_q) * ADDR_W'(LEVEL_DEPTH);
	assign t_waddr  = lvl_base + ADDR_W'(p_tail);
	assign t_raddr  = lvl_base + ADDR_W'(p_head);
	assign t_we     = (state_q == ST_ARR_WR) && !lvl_full;

	always_comb begin
		ptr_we    = 1'b0;
		ptr_wdata = ptr_rdata;
		case (state_q)
			ST_ARR_WR: begin
				ptr_we    = !lvl_full;
				ptr_wdata = {p_head, tail_nx, p_cnt + 1'b1};
			end
			ST_DSP_RD2: begin
				ptr_we    = 1'b1;
				ptr_wdata = {head_nx, p_tail, p_cnt - 1'b1};
			end
			default: begin
				ptr_we = 1'b0;
			end
		endcase
	end

	prrs_ptr_ram #(.N(LEVELS), .W(ENT_W)) u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ptr_we),
		.addr   (lvl_q),
		.wdata  (ptr_wdata),
		.rdata  (ptr_rdata)
	);

	prrs_task_ram #(.DEPTH(TDEPTH), .W(24)) u_task (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata ({itm_id_q, itm_burst_q}),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// one chunk of the non-empty bitmap per cycle, lowest level first
	assign ne_pad = (NCHK*SCAN_CHUNK)'(ne_q);
	assign slice  = ne_pad[chk_q*SCAN_CHUNK +: SCAN_CHUNK];
	assign hit    = |slice;

	always_comb begin
		first = '0;
		for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
			if (slice[i]) begin
				first = SCW'(i);
			end
		end
	end

	assign found = ((CH_W+SCW+1)'(chk_q) << SCW) + (CH_W+SCW+1)'(first);

	assign q_span   = (quantum_q == 8'd0) ? PHASE_SPAN : {1'b0, quantum_q};
	assign ph_nx    = {1'b0, phase_q} + 9'd1;
	assign phase_nx = (ph_nx >= q_span) ? 8'd0 : ph_nx[7:0];
	assign expired  = started_q && (phase_q == 8'd0);
	assign rem_nx   = (cpu_rem_q == 8'd0) ? 8'd0 : cpu_rem_q - 8'd1;

	assign can_emit  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quantum_q   <= QUANTUM_RESET;
			phase_q     <= '0;
			started_q   <= 1'b0;
			busy_q      <= 1'b0;
			cpu_id_q    <= '0;
			cpu_pr_q    <= '0;
			cpu_rem_q   <= '0;
			ne_q        <= '0;
			out_valid_q <= 1'b0;
			chk_q       <= '0;
			req_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				quantum_q <= cfg_data;
			end
			if (state_q == ST_EMIT && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.opcode == OP_ARRIVAL) begin
							itm_id_q    <= in_data.task_id;
							itm_pr_q    <= in_data.task_priority;
							itm_burst_q <= in_data.task_burst;
							req_q       <= 1'b0;
							lvl_q       <= in_data.task_priority[LVL_W-1:0];
							if ({1'b0, in_data.task_priority} >= 9'(LEVELS)) begin
								res_q   <= '{EV_ARR_DROP, in_data.task_id,
									in_data.task_priority, in_data.task_burst};
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_ARR_RD;
							end
						end else begin
							if (!busy_q) begin
								phase_q   <= phase_nx;
								started_q <= 1'b1;
								chk_q     <= '0;
								state_q   <= ST_SCAN;
							end else begin
								cpu_rem_q <= rem_nx;
								if (rem_nx == 8'd0) begin
									busy_q    <= 1'b0;
									phase_q   <= '0;
									started_q <= 1'b0;
									res_q     <= '{EV_DONE, cpu_id_q, cpu_pr_q, 8'd0};
									state_q   <= ST_EMIT;
								end else if (expired) begin
									busy_q      <= 1'b0;
									phase_q     <= '0;
									started_q   <= 1'b0;
									itm_id_q    <= cpu_id_q;
									itm_pr_q    <= cpu_pr_q;
									itm_burst_q <= rem_nx;
									req_q       <= 1'b1;
									lvl_q       <= cpu_pr_q[LVL_W-1:0];
									state_q     <= ST_ARR_RD;
								end else begin
									phase_q   <= phase_nx;
									started_q <= 1'b1;
									res_q     <= '{EV_RUNNING, cpu_id_q, cpu_pr_q, rem_nx};
									state_q   <= ST_EMIT;
								end
							end
						end
					end
				end
				ST_ARR_RD: begin
					state_q <= ST_ARR_WR;
				end
				ST_ARR_WR: begin
					if (lvl_full) begin
						res_q <= '{(req_q ? EV_REQ_DROP : EV_ARR_DROP), itm_id_q,
							itm_pr_q, itm_burst_q};
					end else begin
						ne_q[lvl_q] <= 1'b1;
						res_q <= '{(req_q ? EV_REQUEUED : EV_QUEUED), itm_id_q,
							itm_pr_q, itm_burst_q};
					end
					state_q <= ST_EMIT;
				end
				ST_SCAN: begin
					if (hit) begin
						lvl_q   <= found[LVL_W-1:0];
						state_q <= ST_DSP_RD;
					end else if (chk_q == CH_W'(NCHK - 1)) begin
						res_q   <= '{EV_IDLE, 16'd0, 8'd0, 8'd0};
						state_q <= ST_EMIT;
					end else begin
						chk_q <= chk_q + 1'b1;
					end
				end
				ST_DSP_RD: begin
					state_q <= ST_DSP_RD2;
				end
				ST_DSP_RD2: begin
					if (p_cnt == CNT_W'(1)) begin
						ne_q[lvl_q] <= 1'b0;
					end
					state_q <= ST_DSP_FIN;
				end
				ST_DSP_FIN: begin
					busy_q    <= 1'b1;
					cpu_id_q  <= t_rdata[23:8];
					cpu_pr_q  <= 8'(lvl_q);
					cpu_rem_q <= t_rdata[7:0];
					res_q     <= '{EV_DISPATCH, t_rdata[23:8], 8'(lvl_q), t_rdata[7:0]};
					state_q   <= ST_DSP_FIN + 3'd1;
				end
				ST_EMIT: begin
					if (can_emit) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// leaving the cpu always clears the quantum phase
	a_phase_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (phase_q == 8'd0 && !started_q))
		else $error("phase not cleared when cpu released");

	// a result is only loaded from the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("output loaded outside emit");

	// never push into a full level
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ARR_WR && ptr_we) |-> (p_cnt < CNT_W'(LEVEL_DEPTH)))
		else $error("push into full level");

	// a dispatch only takes from a level that holds a task
	a_dsp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSP_RD2) |-> (p_cnt != '0))
		else $error("dispatch from empty level");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority round-robin scheduler: a scoreboard
// model predicts each event from the accepted transactions, while directed and random
// arrivals and ticks run under several quantum settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import prrs_pkg::*;

	localparam int NLV = 256;
	localparam int DEP = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	priority_round_robin_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// scheduler shadow state
	logic [7:0]  sh_quantum;
	logic [23:0] sh_store [NLV][DEP];
	int          sh_head [NLV];
	int          sh_tail [NLV];
	int          sh_count [NLV];
	logic        sh_busy;
	logic [15:0] sh_id;
	logic [7:0]  sh_pr;
	logic [7:0]  sh_rem;
	int          sh_phase;
	logic        sh_started;

	out_t expected_events[$];
	int   errors = 0;
	int   n_events = 0;
	int   in_idle_pct = 0;
	int   out_idle_pct = 0;
	int   n_items = 0;

	function automatic logic queue_task(int lv, logic [15:0] id, logic [7:0] bu);
		if (lv >= NLV || sh_count[lv] >= DEP) return 1'b0;
		sh_store[lv][sh_tail[lv]] = {id, bu};
		sh_tail[lv] = (sh_tail[lv] + 1) % DEP;
		sh_count[lv]++;
		return 1'b1;
	endfunction

	function automatic out_t schedule_event(in_t it);
		out_t r;
		logic expired;
		int q;
		logic [23:0] e;
		if (it.opcode == OP_ARRIVAL) begin
			r.event_res = queue_task(int'(it.task_priority), it.task_id, it.task_burst)
				? EV_QUEUED : EV_ARR_DROP;
			r.out_task_id = it.task_id;
			r.out_priority = it.task_priority;
			r.remaining = it.task_burst;
			return r;
		end
		expired = sh_started && sh_phase == 0;
		q = (sh_quantum == 8'd0) ? 256 : int'(sh_quantum);
		sh_phase = (sh_phase + 1 >= q) ? 0 : sh_phase + 1;
		sh_started = 1'b1;
		if (!sh_busy) begin
			for (int lv = 0; lv < NLV; lv++) begin
				if (sh_count[lv] != 0) begin
					e = sh_store[lv][sh_head[lv]];
					sh_head[lv] = (sh_head[lv] + 1) % DEP;
					sh_count[lv]--;
					sh_busy = 1'b1;
					sh_id = e[23:8];
					sh_pr = 8'(lv);
					sh_rem = e[7:0];
					r = '{EV_DISPATCH, sh_id, sh_pr, sh_rem};
					return r;
				end
			end
			r = '{EV_IDLE, 16'd0, 8'd0, 8'd0};
			return r;
		end
		if (sh_rem != 8'd0) sh_rem--;
		if (sh_rem == 8'd0) begin
			sh_busy = 1'b0;
			sh_phase = 0;
			sh_started = 1'b0;
			r = '{EV_DONE, sh_id, sh_pr, 8'd0};
		end else if (expired) begin
			r.event_res = queue_task(int'(sh_pr), sh_id, sh_rem) ? EV_REQUEUED : EV_REQ_DROP;
			r.out_task_id = sh_id;
			r.out_priority = sh_pr;
			r.remaining = sh_rem;
			sh_busy = 1'b0;
			sh_phase = 0;
			sh_started = 1'b0;
		end else begin
			r = '{EV_RUNNING, sh_id, sh_pr, sh_rem};
		end
		return r;
	endfunction

	// valid stays high after acceptance until the next item, an idle cycle or the drain wait drops it
	task automatic send_item(in_t it);
		while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_events.push_back(schedule_event(it));
		n_items++;
	endtask

	task automatic send_arrival(int id, int pr, int bu);
		in_t it;
		it.opcode = OP_ARRIVAL;
		it.task_id = 16'(id);
		it.task_priority = 8'(pr);
		it.task_burst = 8'(bu);
		send_item(it);
	endtask

	task automatic send_tick();
		in_t it;
		it = 33'($urandom);
		it.opcode = OP_TICK;
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_quantum(logic [7:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sh_quantum = v;
		cfg_valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		out_t exp_ev;
		if (out_valid && out_ready) begin
			n_events++;
			if (expected_events.size() == 0) begin
				$error("unexpected transaction %p", out_data);
				errors++;
			end else begin
				exp_ev = expected_events.pop_front();
				if (out_data.event_res !== exp_ev.event_res) begin
					$error("event_res exp %0d got %0d", exp_ev.event_res, out_data.event_res);
					errors++;
				end
				if (out_data.out_task_id !== exp_ev.out_task_id) begin
					$error("out_task_id exp %0h got %0h", exp_ev.out_task_id,
						out_data.out_task_id);
					errors++;
				end
				if (out_data.out_priority !== exp_ev.out_priority) begin
					$error("out_priority exp %0d got %0d", exp_ev.out_priority,
						out_data.out_priority);
					errors++;
				end
				if (out_data.remaining !== exp_ev.remaining) begin
					$error("remaining exp %0d got %0d", exp_ev.remaining, out_data.remaining);
					errors++;
				end
			end
		end
		out_ready <= !(out_idle_pct != 0 && $urandom_range(99) < out_idle_pct);
	end

	task automatic test_directed();
		send_tick();                         // idle tick on empty queues
		send_arrival(16'hFFFF, 255, 255);
		send_arrival(16'h0000, 0, 1);
		send_arrival(16'h1234, 256 - 1, 0);  // zero burst
		send_arrival(16'hA5A5, 3, 0);
		send_tick();                         // dispatch level 0
		send_tick();                         // completes
		send_tick();                         // dispatch level 3 zero burst
		send_tick();
		for (int i = 0; i < 17; i++) send_arrival(i, 7, 2);  // last one dropped
		wait_drained();
	endtask

	task automatic test_preemption(logic [7:0] q);
		write_quantum(q);
		for (int i = 0; i < 16; i++) send_arrival(16'h100 + i, 9, 200);
		for (int i = 0; i < 10; i++) send_tick();
		wait_drained();
	endtask

	task automatic test_random(int n);
		int lv_span;
		for (int i = 0; i < n; i++) begin
			lv_span = ($urandom_range(9) == 0) ? 255 : 3;
			if ($urandom_range(99) < 45)
				send_arrival($urandom, $urandom_range(lv_span),
					($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(12));
			else
				send_tick();
			if (i == n / 2) wait_drained();
		end
	endtask

	initial begin
		for (int lv = 0; lv < NLV; lv++) begin
			sh_head[lv] = 0;
			sh_tail[lv] = 0;
			sh_count[lv] = 0;
		end
		sh_quantum = QUANTUM_RESET;
		sh_busy = 1'b0;
		sh_id = '0;
		sh_pr = '0;
		sh_rem = '0;
		sh_phase = 0;
		sh_started = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_preemption(8'd1);
		test_preemption(8'd0);
		in_idle_pct = 24;
		out_idle_pct = 61;
		write_quantum(8'd3);
		test_random(550);
		in_idle_pct = 61;
		out_idle_pct = 24;
		write_quantum(8'd255);
		test_random(550);
		in_idle_pct = 0;
		out_idle_pct = 0;
		write_quantum(8'd2);
		test_random(550);
		wait_drained();

		$display("covered %0d items, %0d events, quantum 0/1/2/3/255/reset", n_items,
			n_events);
		if (errors == 0 && expected_events.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
